@@ hw/rtl/bqmr_pkg.sv @@
// Shared constants, codes and interface types of the bounded queue with match-remove.
package bqmr_pkg;

  // Storage geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int ACT_W      = 2;
  localparam int STS_W      = 2;
  localparam int PORT_DW    = 32;
  localparam int COUNT_PW   = 5;
  localparam int CAP_W      = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // Capacity register.
  localparam int   CAP_RESET    = 16;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE    = 2'd0,
    STS_FULL    = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_NOMATCH = 2'd3
  } status_t;

  // Read address selection for the entry store.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_SKIP
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD,
    S_SEARCH,
    S_MOVE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    idx_clr;
    logic    idx_inc;
    logic    wr_tail;
    logic    wr_move;
    logic    cnt_dec;
    logic    cap_head;
    logic    give_data;
    logic    finish;
    status_t status;
    rd_sel_t rd_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    full;
    logic    empty;
    logic    match;
    logic    last1;
    logic    last2;
  } dp_stat_t;

endpackage

@@ hw/rtl/bounded_queue_with_match_remove_core.sv @@
// Top level of the bounded queue with match-remove: register port, controller and datapath.
//
//  Channel   Ports                                        Handshake
//  -------   -------------------------------------------  ----------------------------------
//  request   in_action, in_item_value                     start high while busy low
//  result    out_status, out_data_out, out_entry_count     out_valid high for one cycle
//  config    psel, penable, pwrite, paddr, pwdata, prdata write in access phase, pready high
//
//  Add finishes in the dispatch state. Pop and peek read the head; pop then moves
//  the remaining entries down one place each. Remove-match compares entries from
//  the head and moves the entries behind the match down; the pace is set by the
//  single read port of the entry store, one entry a cycle.
//  Reset is synchronous and empties the queue; the capacity returns to sixteen.
//  The result beat cannot be stalled; a new request may be taken in that same cycle.
module bounded_queue_with_match_remove_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bqmr_pkg::ACT_W-1:0]          in_action,
  input  logic [bqmr_pkg::PORT_DW-1:0]        in_item_value,
  output logic                                out_valid,
  output logic [bqmr_pkg::STS_W-1:0]          out_status,
  output logic [bqmr_pkg::PORT_DW-1:0]        out_data_out,
  output logic [bqmr_pkg::COUNT_PW-1:0]       out_entry_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqmr_pkg::APB_AW-1:0]         paddr,
  input  logic [bqmr_pkg::APB_DW-1:0]         pwdata,
  output logic [bqmr_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int CPW = bqmr_pkg::CAP_W;

  logic [CPW-1:0]       cap_r;
  logic                 cap_sel;
  logic                 ctrl_busy;
  bqmr_pkg::ctrl_cmd_t  cmd;
  bqmr_pkg::dp_stat_t   stat;

  // Capacity register on the configuration port.
  assign cap_sel = (paddr[2] == bqmr_pkg::REG_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CPW'(bqmr_pkg::CAP_RESET);
    end else if (psel && penable && pwrite && cap_sel) begin
      cap_r <= pwdata[CPW-1:0];
    end
  end

  assign prdata = cap_sel ? bqmr_pkg::APB_DW'(cap_r) : '0;

  bqmr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  bqmr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_item_value   (in_item_value),
    .cap             (cap_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_entry_count (out_entry_count)
  );

  assign busy = ctrl_busy;

endmodule

@@ hw/rtl/bqmr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bqmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bqmr_ctrl.sv @@
// Controller state machine that sequences add, pop, peek and match-remove.
module bqmr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bqmr_pkg::dp_stat_t   stat,
  output bqmr_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  bqmr_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqmr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bqmr_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = bqmr_pkg::S_DISPATCH;
        end
      end
      bqmr_pkg::S_DISPATCH: begin
        unique case (stat.act)
          bqmr_pkg::ACT_ADD: begin
            state_nxt = bqmr_pkg::S_IDLE;
          end
          bqmr_pkg::ACT_POP, bqmr_pkg::ACT_PEEK: begin
            state_nxt = stat.empty ? bqmr_pkg::S_IDLE : bqmr_pkg::S_HEAD;
          end
          default: begin
            state_nxt = stat.empty ? bqmr_pkg::S_IDLE : bqmr_pkg::S_SEARCH;
          end
        endcase
      end
      bqmr_pkg::S_HEAD: begin
        if (stat.act == bqmr_pkg::ACT_PEEK || stat.last1) begin
          state_nxt = bqmr_pkg::S_IDLE;
        end else begin
          state_nxt = bqmr_pkg::S_MOVE;
        end
      end
      bqmr_pkg::S_SEARCH: begin
        if (stat.match) begin
          state_nxt = stat.last1 ? bqmr_pkg::S_IDLE : bqmr_pkg::S_MOVE;
        end else if (stat.last1) begin
          state_nxt = bqmr_pkg::S_IDLE;
        end
      end
      bqmr_pkg::S_MOVE: begin
        if (stat.last2) begin
          state_nxt = bqmr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bqmr_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd        = '0;
    cmd.status = bqmr_pkg::STS_DONE;
    cmd.rd_sel = bqmr_pkg::RD_ZERO;
    unique case (state_r)
      bqmr_pkg::S_IDLE: begin
        cmd.latch = start;
      end
      bqmr_pkg::S_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        unique case (stat.act)
          bqmr_pkg::ACT_ADD: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.status = bqmr_pkg::STS_FULL;
            end else begin
              cmd.wr_tail = 1'b1;
            end
          end
          bqmr_pkg::ACT_POP, bqmr_pkg::ACT_PEEK: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = bqmr_pkg::STS_EMPTY;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = bqmr_pkg::STS_NOMATCH;
            end
          end
        endcase
      end
      bqmr_pkg::S_HEAD: begin
        cmd.cap_head = 1'b1;
        if (stat.act == bqmr_pkg::ACT_PEEK) begin
          cmd.finish    = 1'b1;
          cmd.give_data = 1'b1;
        end else if (stat.last1) begin
          cmd.finish    = 1'b1;
          cmd.give_data = 1'b1;
          cmd.cnt_dec   = 1'b1;
        end else begin
          cmd.rd_sel = bqmr_pkg::RD_NEXT;
        end
      end
      bqmr_pkg::S_SEARCH: begin
        if (stat.match) begin
          if (stat.last1) begin
            cmd.finish  = 1'b1;
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.rd_sel = bqmr_pkg::RD_NEXT;
          end
        end else if (stat.last1) begin
          cmd.finish = 1'b1;
          cmd.status = bqmr_pkg::STS_NOMATCH;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = bqmr_pkg::RD_NEXT;
        end
      end
      bqmr_pkg::S_MOVE: begin
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.last2) begin
          cmd.finish    = 1'b1;
          cmd.cnt_dec   = 1'b1;
          cmd.give_data = (stat.act == bqmr_pkg::ACT_POP);
        end else begin
          cmd.rd_sel = bqmr_pkg::RD_SKIP;
        end
      end
      default: begin
        cmd.latch = 1'b0;
      end
    endcase
  end

  assign busy = (state_r != bqmr_pkg::S_IDLE);

endmodule

@@ hw/rtl/bqmr_dp.sv @@
// Datapath: request registers, count, scan index, entry store and result registers.
module bqmr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bqmr_pkg::ctrl_cmd_t                 cmd,
  output bqmr_pkg::dp_stat_t                  stat,
  input  logic [bqmr_pkg::ACT_W-1:0]          in_action,
  input  logic [bqmr_pkg::PORT_DW-1:0]        in_item_value,
  input  logic [bqmr_pkg::CAP_W-1:0]          cap,
  output logic                                out_valid,
  output logic [bqmr_pkg::STS_W-1:0]          out_status,
  output logic [bqmr_pkg::PORT_DW-1:0]        out_data_out,
  output logic [bqmr_pkg::COUNT_PW-1:0]       out_entry_count
);

  localparam int DW    = bqmr_pkg::DATA_WIDTH;
  localparam int PDW   = bqmr_pkg::PORT_DW;
  localparam int IW    = bqmr_pkg::IDX_W;
  localparam int NW    = bqmr_pkg::CNT_W;
  localparam int EW    = NW + 1;
  localparam int CW    = (bqmr_pkg::CAP_W > NW) ? bqmr_pkg::CAP_W : NW;
  localparam int CPW   = bqmr_pkg::COUNT_PW;

  bqmr_pkg::action_t act_r;
  logic [DW-1:0]     val_r;
  logic [NW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [DW-1:0]     head_r, head_nxt;
  logic              out_valid_r;
  logic [bqmr_pkg::STS_W-1:0] out_status_r;
  logic [PDW-1:0]    out_data_r;

  logic [EW-1:0]     idx_e, cnt_e, idx_p1, idx_p2;
  logic [CW-1:0]     cnt_c, cap_c;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  // Index arithmetic, kept one bit wider than the count.
  assign idx_e  = EW'(idx_r);
  assign cnt_e  = EW'(count_r);
  assign idx_p1 = idx_e + EW'(1);
  assign idx_p2 = idx_e + EW'(2);
  assign cnt_c  = CW'(count_r);
  assign cap_c  = CW'(cap);

  // Status towards the controller.
  assign stat.act   = act_r;
  assign stat.full  = (cnt_c >= cap_c) || (cnt_c >= CW'(bqmr_pkg::DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.match = (ram_rdata == val_r);
  assign stat.last1 = (idx_p1 >= cnt_e);
  assign stat.last2 = (idx_p2 >= cnt_e);

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      bqmr_pkg::RD_NEXT: ram_raddr = idx_p1[IW-1:0];
      bqmr_pkg::RD_SKIP: ram_raddr = idx_p2[IW-1:0];
      default:           ram_raddr = '0;
    endcase
  end

  // Write port: append at the tail, or move an entry down one place.
  assign ram_we    = cmd.wr_tail || cmd.wr_move;
  assign ram_waddr = cmd.wr_tail ? count_r[IW-1:0] : idx_r;
  assign ram_wdata = cmd.wr_tail ? val_r : ram_rdata;

  bqmr_ram #(
    .WIDTH (DW),
    .DEPTH (bqmr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next values of count, index and captured head word.
  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_tail) begin
      count_nxt = count_r + NW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - NW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_p1[IW-1:0];
    end
    head_nxt = cmd.cap_head ? ram_rdata : head_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= bqmr_pkg::action_t'(in_action);
      val_r <= DW'(in_item_value);
    end
    idx_r  <= idx_nxt;
    head_r <= head_nxt;
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_data_r   <= cmd.give_data ? PDW'(head_nxt) : '0;
    end
  end

  // Result beat; the count register already holds the count after the action.
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_entry_count = CPW'(count_r);

endmodule

@@ hw/rtl/bqmr_chk.sv @@
// Port-level checker for the bounded queue with match-remove, bound to the top level.
module bqmr_chk (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [bqmr_pkg::ACT_W-1:0]          in_action,
  input  logic [bqmr_pkg::PORT_DW-1:0]        in_item_value,
  input  logic                                out_valid,
  input  logic [bqmr_pkg::STS_W-1:0]          out_status,
  input  logic [bqmr_pkg::PORT_DW-1:0]        out_data_out,
  input  logic [bqmr_pkg::COUNT_PW-1:0]       out_entry_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqmr_pkg::APB_AW-1:0]         paddr,
  input  logic [bqmr_pkg::APB_DW-1:0]         pwdata,
  input  logic [bqmr_pkg::APB_DW-1:0]         prdata,
  input  logic                                pready
);

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result beat only ends a busy period.
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in progress");

  // Result beats never come back to back.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in consecutive cycles");

  // An empty report leaves an empty queue and no data.
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bqmr_pkg::STS_EMPTY) |->
      (out_entry_count == '0 && out_data_out == '0))
    else $error("empty status with stored words or data");

  // The count on a result beat never exceeds the storage depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= bqmr_pkg::COUNT_PW'(bqmr_pkg::DEPTH)))
    else $error("entry count beyond depth");

endmodule

bind bounded_queue_with_match_remove_core bqmr_chk u_bqmr_chk (.*);

@@ tb/bounded_queue_with_match_remove_core_tb.sv @@
// Self-checking testbench for the bounded queue with match-remove core.
`timescale 1ns / 100ps

module bounded_queue_with_match_remove_core_tb;
  import bqmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 120;

  // One expected result beat.
  typedef struct {
    status_t            status;
    logic [PORT_DW-1:0] data;
    logic [COUNT_PW-1:0] count;
  } queue_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  // Mirror of the queue contents and capacity, with the results still owed.
  class queue_mirror;
    logic [PORT_DW-1:0] words[$];
    logic [CAP_W-1:0]   capacity;
    queue_result_t      owed[$];
    int                 failures;

    function new();
      capacity = CAP_W'(CAP_RESET);
      failures = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // A word already held, so that remove requests find a match often.
    function logic [PORT_DW-1:0] pick_stored();
      if (words.size() == 0)
        return $urandom();
      return words[$urandom_range(0, words.size() - 1)];
    endfunction

    // Apply an accepted request and queue the result it must produce.
    function void note_request(action_t act, logic [PORT_DW-1:0] value);
      queue_result_t res;
      int            limit;
      int            hit;
      res.status = STS_DONE;
      res.data   = '0;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      case (act)
        ACT_ADD: begin
          if (words.size() >= limit || words.size() >= DEPTH)
            res.status = STS_FULL;
          else
            words.push_back(value);
        end
        ACT_POP: begin
          if (words.size() == 0)
            res.status = STS_EMPTY;
          else
            res.data = words.pop_front();
        end
        ACT_PEEK: begin
          if (words.size() == 0)
            res.status = STS_EMPTY;
          else
            res.data = words[0];
        end
        default: begin
          hit = -1;
          foreach (words[i]) begin
            if (hit < 0 && words[i] == value)
              hit = i;
          end
          if (hit < 0)
            res.status = STS_NOMATCH;
          else
            words.delete(hit);
        end
      endcase
      res.count = COUNT_PW'(words.size());
      owed.push_back(res);
    endfunction

    // Compare one result beat with the oldest owed result.
    function void check_result(logic [STS_W-1:0] status, logic [PORT_DW-1:0] data,
                               logic [COUNT_PW-1:0] count);
      queue_result_t exp_res;
      if (owed.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat: status %0d data %h count %0d",
                 $time, status, data, count);
        return;
      end
      exp_res = owed.pop_front();
      if (status !== exp_res.status) begin
        failures++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_res.status, status);
      end
      if (data !== exp_res.data) begin
        failures++;
        $display("%0t: data_out mismatch: expected %h, actual %h",
                 $time, exp_res.data, data);
      end
      if (count !== exp_res.count) begin
        failures++;
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, exp_res.count, count);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ACT_W-1:0]     in_action;
  logic [PORT_DW-1:0]   in_item_value;
  logic                 out_valid;
  logic [STS_W-1:0]     out_status;
  logic [PORT_DW-1:0]   out_data_out;
  logic [COUNT_PW-1:0]  out_entry_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  queue_mirror mirror = new();
  int          idle_cycles = 0;

  bounded_queue_with_match_remove_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_entry_count (out_entry_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result beats cannot be stalled, so every strobe is checked on the spot.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      mirror.check_result(out_status, out_data_out, out_entry_count);
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_queue_with_match_remove_core verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all in steady stretches.
  function automatic int random_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request beat after an optional gap and hold it until taken.
  task automatic send_request(input action_t act, input logic [PORT_DW-1:0] value,
                              input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_action     <= act;
    in_item_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_request(act, value);
  endtask

  // Let every owed result arrive and the core go idle.
  task automatic drain_queue();
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
    while (mirror.pending() != 0 || busy) @(negedge clk);
  endtask

  // Write the capacity register while idle, then read it back.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_queue();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mirror.set_capacity(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CAP_W-1:0] !== value) begin
      mirror.failures++;
      $display("%0t: capacity readback mismatch: expected %0d, actual %0d",
               $time, value, prdata[CAP_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One phase of random traffic with a given mix of actions.
  task automatic random_phase(input traffic_mix_t mix, input int items);
    action_t            act;
    logic [PORT_DW-1:0] value;
    int                 r;
    bit                 steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  act = (r < 60) ? ACT_ADD : (r < 75) ? ACT_POP :
                         (r < 85) ? ACT_PEEK : ACT_REMOVE;
        MIX_DRAIN: act = (r < 20) ? ACT_ADD : (r < 60) ? ACT_POP :
                         (r < 70) ? ACT_PEEK : ACT_REMOVE;
        default:   act = (r < 40) ? ACT_ADD : (r < 65) ? ACT_POP :
                         (r < 75) ? ACT_PEEK : ACT_REMOVE;
      endcase
      // Small values make duplicates; stored values make removals hit.
      if (act == ACT_REMOVE && $urandom_range(0, 9) < 6)
        value = mirror.pick_stored();
      else if ($urandom_range(0, 3) == 0)
        value = $urandom_range(0, 7);
      else
        value = $urandom();
      send_request(act, value, random_gap(steady));
      if (n % 40 == 39)
        steady = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int caps[12];
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_ADD;
    in_item_value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    caps = '{16, 31, 5, 0, 16, 1, 20, 15, 2, 31, 9, 16};
    caps[10] = $urandom_range(0, 31);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Empty queue: pop and peek report empty, remove finds nothing.
    send_request(ACT_POP, 32'hffff_ffff, 0);
    send_request(ACT_PEEK, 32'h0, 0);
    send_request(ACT_REMOVE, 32'h0, 1);
    // Extreme values and a duplicate pair.
    send_request(ACT_ADD, 32'h0, 0);
    send_request(ACT_ADD, 32'hffff_ffff, 0);
    send_request(ACT_ADD, 32'h1234_5678, 2);
    send_request(ACT_ADD, 32'h1234_5678, 0);
    send_request(ACT_ADD, 32'ha5a5_a5a5, 0);
    send_request(ACT_PEEK, 32'h5a5a_5a5a, 0);
    // Only the duplicate nearest the head goes; then a miss on a full search.
    send_request(ACT_REMOVE, 32'h1234_5678, 0);
    send_request(ACT_REMOVE, 32'hdead_beef, 0);
    send_request(ACT_POP, 32'h0, 0);

    // Zero capacity refuses every add.
    set_capacity(5'd0);
    send_request(ACT_ADD, 32'h5555_aaaa, 0);
    send_request(ACT_POP, 32'h0, 0);
    send_request(ACT_ADD, 32'haaaa_5555, 0);

    // Capacity below the count: adds stay full while the count is not under it.
    set_capacity(5'd1);
    send_request(ACT_ADD, 32'h0000_0001, 0);
    send_request(ACT_REMOVE, 32'ha5a5_a5a5, 0);
    send_request(ACT_ADD, 32'h8000_0000, 0);
    send_request(ACT_ADD, 32'h7fff_ffff, 0);
    send_request(ACT_PEEK, 32'h0, 0);

    // Random phases over a spread of capacities, the extremes among them.
    foreach (caps[p]) begin
      set_capacity(CAP_W'(caps[p]));
      case (p % 3)
        0:       random_phase(MIX_FILL, PHASE_ITEMS);
        1:       random_phase(MIX_EVEN, PHASE_ITEMS);
        default: random_phase(MIX_DRAIN, PHASE_ITEMS);
      endcase
    end

    drain_queue();
    repeat (DEPTH + 4) @(negedge clk);
    if (mirror.failures == 0)
      $display("bounded_queue_with_match_remove_core verification clean");
    else
      $display("bounded_queue_with_match_remove_core verification failed");
    $finish;
  end

endmodule

@@ bounded_queue_with_match_remove_core.f @@
hw/rtl/bqmr_pkg.sv
hw/rtl/bqmr_ram.sv
hw/rtl/bqmr_ctrl.sv
hw/rtl/bqmr_dp.sv
hw/rtl/bounded_queue_with_match_remove_core.sv
hw/rtl/bqmr_chk.sv
tb/bounded_queue_with_match_remove_core_tb.sv
